### rtl/core/b64u_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and the character classifier for the base64url decoder.
// Used by b64u_front, b64u_queue, b64u_back and the top level.
package b64u_pkg;

    localparam int unsigned GROUP_SEXTETS     = 4;
    localparam int unsigned LOWER_BASE        = 26;
    localparam int unsigned DIGIT_BASE        = 52;
    localparam int unsigned HYPHEN_SEXTET     = 62;
    localparam int unsigned UNDERSCORE_SEXTET = 63;

    localparam int unsigned SEXTET_W  = 6;
    localparam int unsigned PHASE_W   = $clog2(GROUP_SEXTETS);
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic       MODE_CHAR = 1'b0;
    localparam logic       MODE_END  = 1'b1;
    localparam logic       KIND_DATA   = 1'b0;
    localparam logic       KIND_STATUS = 1'b1;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_CHAR = 2'd1;
    localparam logic [1:0] STATUS_BAD_LEN  = 2'd2;

    typedef enum logic [1:0] {
        OP_SKIP   = 2'd0,
        OP_SEXTET = 2'd1,
        OP_BAD    = 2'd2,
        OP_END    = 2'd3
    } t_op;

    // Classified request passed from front to back
    typedef struct packed {
        t_op                 op;
        logic [SEXTET_W-1:0] sextet;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic t_item classify(input logic mode, input logic [7:0] c);
        t_item it;
        logic [7:0] v;
        it.op     = OP_BAD;
        it.sextet = '0;
        v         = '0;
        if (mode == MODE_END) begin
            it.op = OP_END;
        end else if ((c >= 8'd9 && c <= 8'd13) || c == 8'd32) begin
            it.op = OP_SKIP;
        end else if (c >= 8'd65 && c <= 8'd90) begin
            it.op = OP_SEXTET;
            v     = c - 8'd65;
        end else if (c >= 8'd97 && c <= 8'd122) begin
            it.op = OP_SEXTET;
            v     = c - 8'd97 + 8'(LOWER_BASE);
        end else if (c >= 8'd48 && c <= 8'd57) begin
            it.op = OP_SEXTET;
            v     = c - 8'd48 + 8'(DIGIT_BASE);
        end else if (c == 8'd45) begin
            it.op = OP_SEXTET;
            v     = 8'(HYPHEN_SEXTET);
        end else if (c == 8'd95) begin
            it.op = OP_SEXTET;
            v     = 8'(UNDERSCORE_SEXTET);
        end
        it.sextet = v[SEXTET_W-1:0];
        return it;
    endfunction

endpackage

### rtl/core/base64url_stream_decoder_core.sv
`timescale 1ns / 1ps
// Streaming base64url (unpadded) decoder, one character per input request.
// Input channel: i_in_valid / o_in_ready with i_mode (0 character, 1 end of
// string) and i_char_code. Output channel: o_out_valid / i_out_ready with
// o_kind (0 data byte, 1 final status), o_out_byte and o_status.
// A request is written into the two-entry queue when it is accepted and moves
// into the output register once that register is free; its byte or status is
// then valid at the output.
// Throughput: one request per cycle sustained while the receiver does not stall;
// the back end retires one queued request per cycle into the single output register.
// Whitespace is dropped in the front end; an invalid character sets a sticky
// flag. Bytes are emitted as decoded, so on a non-ok status the consumer
// discards that string's bytes. The end request returns the status and clears
// the group state.
// Reset (i_rst_n low, synchronous) empties the queue and output register and
// clears all decoder state. When the receiver stalls, the output register
// holds its result, the queue fills after two more requests that are not
// whitespace and o_in_ready drops.
// Depends on b64u_pkg, b64u_front, b64u_queue, b64u_back.
module base64url_stream_decoder_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_mode,
    input  logic [7:0] i_char_code,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_kind,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_status
);

    b64u_pkg::t_item     w_push_item;
    b64u_pkg::t_item     w_head_item;
    b64u_pkg::t_q_status w_q_status;
    logic                w_push;
    logic                w_pop;

    b64u_front u_front (
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_char_code (i_char_code),
        .i_q_status  (w_q_status),
        .o_push      (w_push),
        .o_item      (w_push_item)
    );

    b64u_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_item   (w_push_item),
        .i_pop    (w_pop),
        .o_item   (w_head_item),
        .o_status (w_q_status)
    );

    b64u_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (w_head_item),
        .i_q_status  (w_q_status),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_kind      (o_kind),
        .o_out_byte  (o_out_byte),
        .o_status    (o_status)
    );

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_data_has_zero_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == b64u_pkg::KIND_DATA) |-> o_status == b64u_pkg::STATUS_OK)
        else $error("data byte carries a status");

    a_status_has_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == b64u_pkg::KIND_STATUS) |->
        (o_out_byte == 8'd0 && o_status <= b64u_pkg::STATUS_BAD_LEN))
        else $error("malformed status result");

    a_blank_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_mode == b64u_pkg::MODE_CHAR &&
         i_char_code == 8'd32 && w_q_status.empty && !o_out_valid) |=> !o_out_valid)
        else $error("whitespace produced a result");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_status.empty |-> !w_pop)
        else $error("back end read an empty queue");

endmodule

### rtl/core/b64u_front.sv
`timescale 1ns / 1ps
// Front end: accepts character requests, classifies them and pushes them
// into the queue. Whitespace is dropped here. Depends on b64u_pkg.
module b64u_front (
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_mode,
    input  logic [7:0]        i_char_code,
    input  b64u_pkg::t_q_status i_q_status,
    output logic              o_push,
    output b64u_pkg::t_item   o_item
);

    b64u_pkg::t_item w_item;

    always_comb begin
        w_item = b64u_pkg::classify(i_mode, i_char_code);
    end

    assign o_in_ready = !i_q_status.full;
    assign o_item     = w_item;
    assign o_push     = i_in_valid && o_in_ready && (w_item.op != b64u_pkg::OP_SKIP);

endmodule

### rtl/core/b64u_queue.sv
`timescale 1ns / 1ps
// Two-entry queue between front and back ends.
// Depends on b64u_pkg for the item and status types.
module b64u_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  b64u_pkg::t_item     i_item,
    input  logic                i_pop,
    output b64u_pkg::t_item     o_item,
    output b64u_pkg::t_q_status o_status
);

    localparam int unsigned PTR_W = $clog2(b64u_pkg::QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(b64u_pkg::QUEUE_DEPTH + 1);

    b64u_pkg::t_item r_mem [b64u_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_item          = r_mem[r_rd_ptr];
    assign o_status.full   = (r_count == CNT_W'(b64u_pkg::QUEUE_DEPTH));
    assign o_status.empty  = (r_count == '0);

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

### rtl/core/b64u_back.sv
`timescale 1ns / 1ps
// Back end: group state, byte splicing, status and the output register.
// Depends on b64u_pkg.
module b64u_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  b64u_pkg::t_item     i_item,
    input  b64u_pkg::t_q_status i_q_status,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_kind,
    output logic [7:0]          o_out_byte,
    output logic [1:0]          o_status
);

    localparam int unsigned SW = b64u_pkg::SEXTET_W;

    logic [b64u_pkg::PHASE_W-1:0] r_phase, n_phase;
    logic [SW-1:0]                r_held, n_held;
    logic                         r_bad, n_bad;
    logic                         r_valid, n_valid;
    logic                         r_kind, n_kind;
    logic [7:0]                   r_byte, n_byte;
    logic [1:0]                   r_stat, n_stat;
    logic                         w_slot_free;

    assign w_slot_free = !r_valid || i_out_ready;
    assign o_pop       = w_slot_free && !i_q_status.empty;

    always_comb begin
        n_phase = r_phase;
        n_held  = r_held;
        n_bad   = r_bad;
        n_valid = r_valid && !i_out_ready;
        n_kind  = r_kind;
        n_byte  = r_byte;
        n_stat  = r_stat;
        if (o_pop) begin
            case (i_item.op)
                b64u_pkg::OP_END: begin
                    n_valid = 1'b1;
                    n_kind  = b64u_pkg::KIND_STATUS;
                    n_byte  = '0;
                    if (r_bad) begin
                        n_stat = b64u_pkg::STATUS_BAD_CHAR;
                    end else if (r_phase == b64u_pkg::PHASE_W'(1)) begin
                        n_stat = b64u_pkg::STATUS_BAD_LEN;
                    end else begin
                        n_stat = b64u_pkg::STATUS_OK;
                    end
                    n_phase = '0;
                    n_held  = '0;
                    n_bad   = 1'b0;
                end
                b64u_pkg::OP_BAD: begin
                    n_bad = 1'b1;
                end
                b64u_pkg::OP_SEXTET: begin
                    n_held  = i_item.sextet;
                    n_phase = r_phase + 1'b1;
                    n_kind  = b64u_pkg::KIND_DATA;
                    n_stat  = b64u_pkg::STATUS_OK;
                    // Phase 0 only stores the sextet; later phases splice a byte
                    case (r_phase)
                        2'd1: n_byte = {r_held, i_item.sextet[5:4]};
                        2'd2: n_byte = {r_held[3:0], i_item.sextet[5:2]};
                        2'd3: n_byte = {r_held[1:0], i_item.sextet};
                        default: n_byte = r_byte;
                    endcase
                    n_valid = (r_phase != '0);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_held  <= '0;
            r_bad   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_held  <= n_held;
            r_bad   <= n_bad;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_byte <= n_byte;
        r_stat <= n_stat;
    end

    assign o_out_valid = r_valid;
    assign o_kind      = r_kind;
    assign o_out_byte  = r_byte;
    assign o_status    = r_stat;

endmodule

### dv/base64url_stream_decoder_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for base64url_stream_decoder_core: directed table, then random strings
// checked against an in-bench decoder model. Depends on b64u_pkg and the core.
module base64url_stream_decoder_core_tb;

    localparam int unsigned CYCLE_LIMIT  = 200_000;
    localparam int unsigned PHASE_ITEMS  = 305;
    localparam int unsigned LONG_HOLD    = 300;
    localparam int unsigned SETTLE_TICKS = 6;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic [1:0] status;
    } t_dec_result;

    typedef struct packed {
        logic        mode;
        logic [7:0]  code;
        logic        fixed;
        t_dec_result want;
    } t_dir_row;

    localparam t_dec_result WANT_OK =
        '{b64u_pkg::KIND_STATUS, 8'h00, b64u_pkg::STATUS_OK};
    localparam t_dec_result WANT_BAD_LEN =
        '{b64u_pkg::KIND_STATUS, 8'h00, b64u_pkg::STATUS_BAD_LEN};
    localparam t_dec_result WANT_BAD_CHAR =
        '{b64u_pkg::KIND_STATUS, 8'h00, b64u_pkg::STATUS_BAD_CHAR};
    localparam t_dec_result WANT_FF = '{b64u_pkg::KIND_DATA, 8'hFF, b64u_pkg::STATUS_OK};
    localparam t_dec_result WANT_00 = '{b64u_pkg::KIND_DATA, 8'h00, b64u_pkg::STATUS_OK};

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       i_mode      = b64u_pkg::MODE_CHAR;
    logic [7:0] i_char_code = 8'd0;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic       o_kind;
    logic [7:0] o_out_byte;
    logic [1:0] o_status;

    // decoder model state
    logic [1:0] dec_phase = '0;
    logic [5:0] dec_held  = '0;
    logic       dec_bad   = 1'b0;

    t_dec_result decoded_due[$];
    int unsigned items_sent     = 0;
    int unsigned mismatches     = 0;
    int unsigned cycle_count    = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_req       = 0;
    int unsigned hold_seen      = 0;
    int unsigned hold_left      = 0;

    // fixed rows hold results that follow directly from the alphabet
    t_dir_row dir_table [0:24] = '{
        '{b64u_pkg::MODE_END,  8'h00, 1'b1, WANT_OK},
        '{b64u_pkg::MODE_CHAR, "_",   1'b0, '0},
        '{b64u_pkg::MODE_CHAR, "_",   1'b1, WANT_FF},
        '{b64u_pkg::MODE_CHAR, "_",   1'b1, WANT_FF},
        '{b64u_pkg::MODE_CHAR, "_",   1'b1, WANT_FF},
        '{b64u_pkg::MODE_END,  8'hFF, 1'b1, WANT_OK},
        '{b64u_pkg::MODE_CHAR, "Q",   1'b0, '0},
        '{b64u_pkg::MODE_CHAR, 8'd9,  1'b0, '0},
        '{b64u_pkg::MODE_END,  8'h00, 1'b1, WANT_BAD_LEN},
        '{b64u_pkg::MODE_CHAR, "A",   1'b0, '0},
        '{b64u_pkg::MODE_CHAR, 8'd32, 1'b0, '0},
        '{b64u_pkg::MODE_CHAR, 8'd13, 1'b0, '0},
        '{b64u_pkg::MODE_CHAR, "A",   1'b1, WANT_00},
        '{b64u_pkg::MODE_CHAR, 8'h00, 1'b0, '0},
        '{b64u_pkg::MODE_CHAR, 8'hFF, 1'b0, '0},
        '{b64u_pkg::MODE_CHAR, "z",   1'b0, '0},
        '{b64u_pkg::MODE_CHAR, "-",   1'b0, '0},
        '{b64u_pkg::MODE_CHAR, "0",   1'b0, '0},
        '{b64u_pkg::MODE_CHAR, "9",   1'b0, '0},
        '{b64u_pkg::MODE_END,  8'h00, 1'b1, WANT_BAD_CHAR},
        '{b64u_pkg::MODE_CHAR, 8'd8,  1'b0, '0},
        '{b64u_pkg::MODE_CHAR, "a",   1'b0, '0},
        '{b64u_pkg::MODE_END,  8'h00, 1'b1, WANT_BAD_CHAR},
        '{b64u_pkg::MODE_CHAR, "Z",   1'b0, '0},
        '{b64u_pkg::MODE_END,  8'h00, 1'b1, WANT_BAD_LEN}
    };

    base64url_stream_decoder_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_char_code (i_char_code),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_kind      (o_kind),
        .o_out_byte  (o_out_byte),
        .o_status    (o_status)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic bit is_blank(input logic [7:0] c);
        return (c >= 8'd9 && c <= 8'd13) || c == 8'd32;
    endfunction

    // {hit, sextet}
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        if (c >= "A" && c <= "Z") return {1'b1, 6'(c - "A")};
        if (c >= "a" && c <= "z") return {1'b1, 6'(c - "a" + b64u_pkg::LOWER_BASE)};
        if (c >= "0" && c <= "9") return {1'b1, 6'(c - "0" + b64u_pkg::DIGIT_BASE)};
        if (c == "-") return {1'b1, 6'(b64u_pkg::HYPHEN_SEXTET)};
        if (c == "_") return {1'b1, 6'(b64u_pkg::UNDERSCORE_SEXTET)};
        return 7'd0;
    endfunction

    function automatic logic [7:0] sextet_char(input logic [5:0] s);
        if (s < b64u_pkg::LOWER_BASE) return 8'("A" + s);
        if (s < b64u_pkg::DIGIT_BASE) return 8'("a" + s - b64u_pkg::LOWER_BASE);
        if (s < b64u_pkg::HYPHEN_SEXTET) return 8'("0" + s - b64u_pkg::DIGIT_BASE);
        if (s == b64u_pkg::HYPHEN_SEXTET) return "-";
        return "_";
    endfunction

    // Advances the model by one request; returns 1 when it yields a result
    function automatic bit decode_char(input logic m, input logic [7:0] c,
                                       output t_dec_result res);
        logic [6:0] sx;
        res = '0;
        if (m == b64u_pkg::MODE_END) begin
            res.kind = b64u_pkg::KIND_STATUS;
            if (dec_bad) res.status = b64u_pkg::STATUS_BAD_CHAR;
            else if (dec_phase == 2'd1) res.status = b64u_pkg::STATUS_BAD_LEN;
            else res.status = b64u_pkg::STATUS_OK;
            dec_phase = '0;
            dec_held  = '0;
            dec_bad   = 1'b0;
            return 1'b1;
        end
        if (is_blank(c)) return 1'b0;
        sx = sextet_of(c);
        if (!sx[6]) begin
            dec_bad = 1'b1;
            return 1'b0;
        end
        if (dec_phase == 2'd0) begin
            dec_held  = sx[5:0];
            dec_phase = 2'd1;
            return 1'b0;
        end
        res.kind = b64u_pkg::KIND_DATA;
        case (dec_phase)
            2'd1:    res.data = {dec_held, sx[5:4]};
            2'd2:    res.data = {dec_held[3:0], sx[5:2]};
            default: res.data = {dec_held[1:0], sx[5:0]};
        endcase
        dec_held  = sx[5:0];
        dec_phase = dec_phase + 2'd1;
        return 1'b1;
    endfunction

    task automatic offer(input logic m, input logic [7:0] c, input logic fixed,
                         input t_dec_result want);
        t_dec_result res;
        bit has;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_mode      <= m;
        i_char_code <= c;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        has = decode_char(m, c, res);
        if (has) decoded_due.push_back(fixed ? want : res);
        items_sent++;
    endtask

    // sender stops and waits for every awaited result, plus pipeline latency
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (decoded_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = LONG_HOLD;
        end
        if (hold_left != 0) begin
            hold_left   = hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_dec_result got;
        t_dec_result want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            got = '{o_kind, o_out_byte, o_status};
            if (decoded_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: kind %b byte %h status %0d",
                             got.kind, got.data, got.status);
            end else begin
                want = decoded_due.pop_front();
                if (got.kind !== want.kind || got.data !== want.data
                        || got.status !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp kind %b byte %h status %0d, ",
                                  "got kind %b byte %h status %0d"},
                                 want.kind, want.data, want.status,
                                 got.kind, got.data, got.status);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin : stimulus
        t_dec_result none;
        logic [6:0]  sx;
        logic [7:0]  c;
        int unsigned len;
        int unsigned bad_at;
        int unsigned phase_start;
        int unsigned k;
        int unsigned ph;
        none = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_table[i])
            offer(dir_table[i].mode, dir_table[i].code, dir_table[i].fixed,
                  dir_table[i].want);
        settle();

        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    hold_req++;     // receiver blocks for a while; input must back up
                end
                1: begin
                    send_idle_pct  = 82;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 82;
                end
                default: begin
                    send_idle_pct  = 22;
                    recv_stall_pct = 22;
                end
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < 85) begin
                    // string of random length from the alphabet, occasionally spoiled by one bad byte
                    len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 64)
                                                       : $urandom_range(0, 12);
                    bad_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len) : len + 1;
                    for (k = 0; k <= len; k++) begin
                        if (k == bad_at) begin
                            do begin
                                c  = 8'($urandom_range(0, 255));
                                sx = sextet_of(c);
                            end while (sx[6] || is_blank(c));
                            offer(b64u_pkg::MODE_CHAR, c, 1'b0, none);
                        end
                        if ($urandom_range(0, 11) == 0) begin
                            c = 8'($urandom_range(9, 14));
                            if (c == 8'd14) c = 8'd32;
                            offer(b64u_pkg::MODE_CHAR, c, 1'b0, none);
                        end
                        if (k < len)
                            offer(b64u_pkg::MODE_CHAR,
                                  sextet_char(6'($urandom_range(0, 63))), 1'b0, none);
                    end
                    offer(b64u_pkg::MODE_END, 8'($urandom_range(0, 255)), 1'b0, none);
                end else begin
                    repeat ($urandom_range(1, 8))
                        offer(($urandom_range(0, 7) == 0) ? b64u_pkg::MODE_END
                                                          : b64u_pkg::MODE_CHAR,
                              8'($urandom_range(0, 255)), 1'b0, none);
                end
            end
            settle();
        end

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
